// File: design/akbd_pkg.sv
// ----------------------------------------------------------------------------
// akbd_pkg
// Shared types and constants of the address-keyed bit-swap byte decryptor.
// ----------------------------------------------------------------------------
package akbd_pkg;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_KEY_LOW      = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_KEY_HIGH     = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ADDRESS_OFFSET_KEY = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_BYTE_XOR_KEY      = 8'd3;

	// address scramble applied before forming the data selector
	localparam logic [15:0] DATA_ADDR_XOR = 16'h1fc0;

	// key set seen by the decrypt datapath
	typedef struct packed {
		logic [31:0] swap_key_low;
		logic [31:0] swap_key_high;
		logic [15:0] address_offset_key;
		logic [7:0]  byte_xor_key;
	} akbd_cfg_t;

endpackage

// File: design/akbd_cfg_regs.sv
// ----------------------------------------------------------------------------
// akbd_cfg_regs
// Key register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module akbd_cfg_regs
	import akbd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output akbd_cfg_t              keys
);

	akbd_cfg_t keys_q;

	// every word is taken at once
	assign cfg_ready = 1'b1;

	// register write, out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SWAP_KEY_LOW:       keys_q.swap_key_low       <= cfg_data;
				CFG_SWAP_KEY_HIGH:      keys_q.swap_key_high      <= cfg_data;
				CFG_ADDRESS_OFFSET_KEY: keys_q.address_offset_key <= cfg_data[15:0];
				CFG_BYTE_XOR_KEY:       keys_q.byte_xor_key       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign keys = keys_q;

endmodule

// File: design/akbd_decrypt.sv
// ----------------------------------------------------------------------------
// akbd_decrypt
// Four-stage pair-swap / rotate / xor decrypt of one byte under a selector.
// ----------------------------------------------------------------------------
module akbd_decrypt
	import akbd_pkg::*;
(
	input  akbd_cfg_t   keys,
	input  logic [15:0] selector,
	input  logic [7:0]  cipher,
	output logic [7:0]  plain
);

	// swap each bit pair whose keyed selector bit is set
	function automatic logic [7:0] pair_swap(input logic [7:0] v, input logic [15:0] key,
			input logic [7:0] sel);
		logic [7:0] r;
		logic [2:0] idx;
		r = v;
		for (int p = 0; p < 4; p++) begin
			idx = key[4*p +: 3];
			if (sel[idx]) begin
				r[2*p +: 2] = {v[2*p], v[2*p+1]};
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] rotl1(input logic [7:0] v);
		return {v[6:0], v[7]};
	endfunction

	logic [7:0] sel_lo;
	logic [7:0] sel_hi;
	logic [7:0] st_a;
	logic [7:0] st_b;
	logic [7:0] st_c;

	assign sel_lo = selector[7:0];
	assign sel_hi = selector[15:8];

	// stages a and b on the low selector byte, c and d on the high byte
	assign st_a  = rotl1(pair_swap(cipher, keys.swap_key_low[15:0], sel_lo));
	assign st_b  = rotl1(pair_swap(st_a, keys.swap_key_low[31:16], sel_lo) ^ keys.byte_xor_key);
	assign st_c  = rotl1(pair_swap(st_b, keys.swap_key_high[15:0], sel_hi));
	assign plain = pair_swap(st_c, keys.swap_key_high[31:16], sel_hi);

endmodule

// File: design/address_keyed_bitswap_byte_decrypt.sv
// ----------------------------------------------------------------------------
// address_keyed_bitswap_byte_decrypt
// Decrypts one ROM byte at a CPU address into an opcode byte and a data byte.
// ----------------------------------------------------------------------------
// Usage:
//   Keys are loaded on the cfg channel (index 0 swap_key_low, 1 swap_key_high,
//   2 address_offset_key, 3 byte_xor_key); cfg_ready is always high and
//   other indexes are ignored. Load keys only while no word is in flight.
//   Each input word (byte_address, cipher_byte) yields exactly one output
//   word (opcode_byte, data_byte).
//   Each accepted word passes one input register stage, then the selector
//   adders and both swap chains ahead of the result register. Throughput is
//   one word per cycle, set by the two-deep register pipeline that advances
//   whenever the result register is empty or being drained.
//   When the receiver stalls, the result holds and the input register keeps
//   one more word; in_ready drops only with both stages full.
//   Reset clears the keys to zero and empties both pipeline stages.
// ----------------------------------------------------------------------------
module address_keyed_bitswap_byte_decrypt
	import akbd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [15:0]            byte_address,
	input  logic [7:0]             cipher_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             opcode_byte,
	output logic [7:0]             data_byte
);

	akbd_cfg_t   keys;
	logic        valid_s1;
	logic [15:0] addr_s1;
	logic [7:0]  cipher_s1;
	logic        valid_s2;
	logic [7:0]  opcode_s2;
	logic [7:0]  data_s2;
	logic        adv_s2;
	logic        load_s1;
	logic [15:0] sel_op;
	logic [15:0] sel_data;
	logic [7:0]  opcode_next;
	logic [7:0]  data_next;

	akbd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.keys      (keys)
	);

	// pipeline flow control
	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;
	assign load_s1  = in_valid && in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			addr_s1   <= byte_address;
			cipher_s1 <= cipher_byte;
		end
	end

	// selector words, both wrap modulo 2^16
	assign sel_op   = addr_s1 + keys.address_offset_key;
	assign sel_data = (addr_s1 ^ DATA_ADDR_XOR) + 16'd1 + keys.address_offset_key;

	akbd_decrypt u_dec_op (
		.keys     (keys),
		.selector (sel_op),
		.cipher   (cipher_s1),
		.plain    (opcode_next)
	);

	akbd_decrypt u_dec_data (
		.keys     (keys),
		.selector (sel_data),
		.cipher   (cipher_s1),
		.plain    (data_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			opcode_s2 <= opcode_next;
			data_s2   <= data_next;
		end
	end

	assign out_valid   = valid_s2;
	assign opcode_byte = opcode_s2;
	assign data_byte   = data_s2;

endmodule

// File: design/akbd_checker.sv
// ----------------------------------------------------------------------------
// akbd_checker
// Port-level checks of the decryptor pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module akbd_checker
	import akbd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] opcode_byte,
	input logic [7:0] data_byte
);

	// stalled result holds its word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(opcode_byte) && $stable(data_byte))
		else $error("result word changed while stalled");

	// an empty result stage never backs up the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result stage");

	// an accepted word reaches out_valid through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("accepted word did not reach the output");

	// no result appears without an input word behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result word without an accepted input");

endmodule

bind address_keyed_bitswap_byte_decrypt akbd_checker u_akbd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.opcode_byte (opcode_byte),
	.data_byte   (data_byte)
);

// File: tb/sv/akbd_decrypt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akbd_decrypt_checker
// Watches the key, input and result channels of the byte decryptor, keeps
// its own copy of the keys, works out the opcode and data bytes for every
// accepted input word and compares them in order with the result words.
// ----------------------------------------------------------------------------
module akbd_decrypt_checker
	import akbd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [15:0]            byte_address,
	input  logic [7:0]             cipher_byte,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [7:0]             opcode_byte,
	input  logic [7:0]             data_byte,
	output int unsigned            fail_count,
	output int unsigned            pending
);

	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] data;
	} clear_pair_t;

	akbd_cfg_t   key_copy;
	clear_pair_t clear_pairs_due[$];
	clear_pair_t oldest;
	int unsigned new_fails;

	// swap each bit pair whose key nibble points at a set selector bit
	function automatic logic [7:0] swap_pairs(logic [7:0] v, logic [15:0] key,
			logic [7:0] sel);
		logic [7:0] r;
		int p;
		r = v;
		for (p = 0; p < 4; p++) begin
			if (sel[key[4*p +: 3]]) begin
				r[2*p +: 2] = {r[2*p], r[2*p+1]};
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] rot_left(logic [7:0] v);
		return {v[6:0], v[7]};
	endfunction

	// four swap stages with rotates and the xor key between them
	function automatic logic [7:0] decrypt_with(logic [7:0] c, logic [15:0] sel,
			akbd_cfg_t k);
		logic [7:0] v;
		v = swap_pairs(c, k.swap_key_low[15:0], sel[7:0]);
		v = rot_left(v);
		v = swap_pairs(v, k.swap_key_low[31:16], sel[7:0]);
		v = v ^ k.byte_xor_key;
		v = rot_left(v);
		v = swap_pairs(v, k.swap_key_high[15:0], sel[15:8]);
		v = rot_left(v);
		v = swap_pairs(v, k.swap_key_high[31:16], sel[15:8]);
		return v;
	endfunction

	// both clear bytes of one input word; selectors wrap at 16 bits
	function automatic clear_pair_t decrypt_pair(logic [15:0] addr, logic [7:0] c,
			akbd_cfg_t k);
		clear_pair_t r;
		logic [15:0] sel_op;
		logic [15:0] sel_data;
		sel_op   = addr + k.address_offset_key;
		sel_data = (addr ^ DATA_ADDR_XOR) + 16'd1 + k.address_offset_key;
		r.opcode = decrypt_with(c, sel_op, k);
		r.data   = decrypt_with(c, sel_data, k);
		return r;
	endfunction

	// key writes, predictions on input words, checks on result words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_copy = '0;
			clear_pairs_due.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			new_fails = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SWAP_KEY_LOW:       key_copy.swap_key_low       = cfg_data;
					CFG_SWAP_KEY_HIGH:      key_copy.swap_key_high      = cfg_data;
					CFG_ADDRESS_OFFSET_KEY: key_copy.address_offset_key = cfg_data[15:0];
					CFG_BYTE_XOR_KEY:       key_copy.byte_xor_key       = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				clear_pairs_due.push_back(decrypt_pair(byte_address, cipher_byte, key_copy));
			end
			if (out_valid && out_ready) begin
				if (clear_pairs_due.size() == 0) begin
					$error("result word with nothing expected: opcode_byte %02h data_byte %02h",
						opcode_byte, data_byte);
					new_fails++;
				end else begin
					oldest = clear_pairs_due.pop_front();
					if (opcode_byte !== oldest.opcode) begin
						$error("opcode_byte mismatch: expected %02h, actual %02h",
							oldest.opcode, opcode_byte);
						new_fails++;
					end
					if (data_byte !== oldest.data) begin
						$error("data_byte mismatch: expected %02h, actual %02h",
							oldest.data, data_byte);
						new_fails++;
					end
				end
			end
			fail_count <= fail_count + new_fails;
			pending    <= clear_pairs_due.size();
		end
	end

endmodule

// File: tb/sv/address_keyed_bitswap_byte_decrypt_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_keyed_bitswap_byte_decrypt_tb
// Drives keys and encrypted bytes into the decryptor with random gaps on both
// channels, a long result stall and drained pauses, across several key sets;
// the checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module address_keyed_bitswap_byte_decrypt_tb;
	import akbd_pkg::*;

	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned SETTLE      = 4;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_WORDS = 192;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [15:0]            byte_address;
	logic [7:0]             cipher_byte;
	logic                   out_valid;
	logic                   out_ready;
	logic [7:0]             opcode_byte;
	logic [7:0]             data_byte;
	int unsigned            fail_count;
	int unsigned            pending;

	bit          no_idle;
	bit          hold_req;
	int unsigned rush_left;
	int unsigned stall_cycles;

	logic [15:0] probe_addr [0:6] = '{16'h0000, 16'hffff, 16'he03f, 16'h1fc0,
		16'h0001, 16'h8000, 16'h7fff};
	logic [7:0]  probe_byte [0:6] = '{8'h00, 8'hff, 8'ha5, 8'h5a, 8'h80, 8'h01, 8'hff};

	address_keyed_bitswap_byte_decrypt uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_address (byte_address),
		.cipher_byte  (cipher_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.opcode_byte  (opcode_byte),
		.data_byte    (data_byte)
	);

	akbd_decrypt_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_address (byte_address),
		.cipher_byte  (cipher_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.opcode_byte  (opcode_byte),
		.data_byte    (data_byte),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// gap before each word, mostly none, sometimes a random one; never while no_idle is set
	function automatic int unsigned draw_gap();
		if (no_idle) return 0;
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
	endfunction

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles + 1 >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int unsigned gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = draw_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic write_key(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// offset and xor key carry junk in the upper bits, which must be dropped
	task automatic load_keys(input logic [31:0] low, input logic [31:0] high,
			input logic [15:0] offset, input logic [7:0] xor_key);
		write_key(CFG_SWAP_KEY_LOW, low);
		write_key(CFG_SWAP_KEY_HIGH, high);
		write_key(CFG_ADDRESS_OFFSET_KEY, {16'($urandom_range(0, 16'hffff)), offset});
		write_key(CFG_BYTE_XOR_KEY, {24'($urandom_range(0, 24'hffffff)), xor_key});
		// out-of-range index, ignored by the block
		write_key(CFG_INDEX_W'($urandom_range(4, 255)), $urandom);
	endtask

	task automatic send_word(input logic [15:0] addr, input logic [7:0] c);
		int unsigned gap;
		gap = draw_gap();
		if (rush_left > 0) begin
			gap = 0;
			rush_left--;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		byte_address <= addr;
		cipher_byte  <= c;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop sending and wait for every outstanding result word
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_probes();
		int i;
		for (i = 0; i < 7; i++) send_word(probe_addr[i], probe_byte[i]);
	endtask

	// stimulus
	initial begin
		int unsigned ph;
		int unsigned n;
		logic [15:0] base;
		logic [15:0] addr;
		logic [7:0]  c;
		logic [31:0] low;
		logic [31:0] high;

		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		byte_address = '0;
		cipher_byte  = '0;
		no_idle      = 1'b0;
		hold_req     = 1'b0;
		rush_left    = 0;
		stall_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes and wrap addresses with reset keys
		send_probes();
		drain();

		// index keys, offset that wraps both selectors
		low  = 32'h7654_3210;
		high = 32'h0123_4567;
		load_keys(low, high, 16'hffff, 8'hc3);
		send_probes();
		drain();

		// same keys with the unused fourth bit of every nibble set
		load_keys(low | 32'h8888_8888, high | 32'h8888_8888, 16'hffff, 8'hc3);
		send_probes();
		drain();

		// random phases over several key sets
		for (ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				load_keys(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 8'hff);
			end else if (ph == 1) begin
				load_keys(32'h0, 32'h0, 16'h0, 8'h0);
			end else begin
				load_keys($urandom, $urandom, 16'($urandom), 8'($urandom));
			end
			no_idle = (ph == 5);
			base = 16'($urandom);
			for (n = 0; n < PHASE_WORDS; n++) begin
				// long result stall while words keep coming
				if (ph == 3 && n == 50) begin
					hold_req  = 1'b1;
					rush_left = 40;
				end
				if (ph % 2 == 1) begin
					addr = base + 16'(n);
				end else if ($urandom_range(0, 9) == 0) begin
					addr = ($urandom_range(0, 1) == 0) ? 16'hffff : 16'h0000;
				end else begin
					addr = 16'($urandom);
				end
				c = 8'($urandom);
				send_word(addr, c);
				// occasional full pause with the pipeline drained
				if (n == PHASE_WORDS / 2 && ph % 3 == 0) drain();
			end
			drain();
		end

		no_idle = 1'b0;
		drain();
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
